>>> rtl/ts_pkg.sv
`default_nettype none
package ts_pkg;

  localparam int TEXEL_DEPTH = 16384;
  localparam int MAX_DIM     = 128;

  localparam int ADDR_W  = $clog2(TEXEL_DEPTH);
  localparam int FA_W    = ADDR_W + 1;
  localparam int DIM_W   = 8;
  localparam int COORD_W = 17;
  localparam int PROD_W  = COORD_W + DIM_W;
  localparam int FRAC_W  = 19;
  localparam int WGT_W   = 2 * FRAC_W;
  localparam int CH_W    = 8;
  localparam int RGB_W   = 24;
  localparam int TERM_W  = WGT_W + CH_W + 1;
  localparam int SUM_W   = TERM_W + 2;

  localparam int QDEPTH  = 8;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  localparam int ODEPTH  = 4;
  localparam int OPTR_W  = $clog2(ODEPTH);
  localparam int OCNT_W  = OPTR_W + 1;

  localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(65536);
  localparam int                 HALF      = 32768;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;
  localparam logic KIND_WRITE    = 1'b0;
  localparam logic KIND_SAMPLE   = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [ADDR_W-1:0]   texel_addr;
    logic [RGB_W-1:0]    texel_rgb;
    logic [COORD_W-1:0]  coord_u;
    logic [COORD_W-1:0]  coord_v;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             mode;
  } ts_cfg_t;

  typedef struct packed {
    logic                     is_write;
    logic [ADDR_W-1:0]        waddr;
    logic [RGB_W-1:0]         wdata;
    logic [FA_W-1:0]          a_tl;
    logic [FA_W-1:0]          a_tr;
    logic [FA_W-1:0]          a_bl;
    logic [FA_W-1:0]          a_br;
    logic signed [FRAC_W-1:0] fu;
    logic signed [FRAC_W-1:0] omfu;
    logic signed [FRAC_W-1:0] fv;
    logic signed [FRAC_W-1:0] omfv;
  } q_entry_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } q_status_t;

endpackage
`default_nettype wire

>>> rtl/ts_front.sv
`default_nettype none
module ts_front
  import ts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire in_item_t  in_data,
  output logic           full,
  input  wire ts_cfg_t   cfg,
  input  wire q_status_t q_stat,
  output logic           q_push,
  output q_entry_t       q_entry
);

  typedef struct packed {
    logic [6:0]               corner;
    logic signed [FRAC_W-1:0] frac;
    logic signed [FRAC_W-1:0] omf;
  } axis_t;

  // Corner and signed fraction along one axis; nearest mode keeps the
  // truncated texel and a zero fraction so the back end sees full weight.
  function automatic axis_t axis_calc(logic [PROD_W-1:0] prod, logic [DIM_W-1:0] dim,
                                      logic mode);
    logic signed [PROD_W:0] p;
    logic signed [PROD_W:0] f;
    logic [7:0]             c;
    logic [DIM_W-1:0]       lim;
    axis_t                  r;
    p   = $signed({1'b0, prod}) - $signed((PROD_W+1)'(HALF));
    lim = dim - 8'd2;
    if (mode == MODE_NEAREST) begin
      c      = prod[23:16];
      r.frac = '0;
    end else begin
      c = p[PROD_W] ? 8'd0 : p[23:16];
      if (c > lim) c = lim;
      f      = p - $signed({2'b00, c, 16'h0000});
      r.frac = f[FRAC_W-1:0];
    end
    r.omf    = $signed(FRAC_W'(65536)) - r.frac;
    r.corner = c[6:0];
    return r;
  endfunction

  logic                accept;
  logic [COORD_W-1:0]  us, vs;
  logic [DIM_W-1:0]    mw, mh;
  logic [3:0]          inflight;

  logic                a_valid_r;
  logic                a_kind_r, a_mode_r;
  logic [ADDR_W-1:0]   a_waddr_r;
  logic [RGB_W-1:0]    a_wdata_r;
  logic [DIM_W-1:0]    a_w_r, a_h_r;
  logic [PROD_W-1:0]   a_pu_r, a_pv_r;

  logic                b_valid_r;
  q_entry_t            b_entry_r, b_entry_nxt;
  axis_t               ax_u, ax_v;
  logic [FA_W-1:0]     tl;

  assign inflight = q_stat.count + QCNT_W'(a_valid_r) + QCNT_W'(b_valid_r);
  assign full     = (inflight >= QCNT_W'(QDEPTH));
  assign accept   = push && !full;

  assign us = (in_data.coord_u > COORD_ONE) ? COORD_ONE : in_data.coord_u;
  assign vs = (in_data.coord_v > COORD_ONE) ? COORD_ONE : in_data.coord_v;
  assign mw = (cfg.mode == MODE_NEAREST) ? cfg.width - 8'd1 : cfg.width;
  assign mh = (cfg.mode == MODE_NEAREST) ? cfg.height - 8'd1 : cfg.height;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= accept;
    end
    if (accept) begin
      a_kind_r  <= in_data.kind;
      a_mode_r  <= cfg.mode;
      a_waddr_r <= in_data.texel_addr;
      a_wdata_r <= in_data.texel_rgb;
      a_w_r     <= cfg.width;
      a_h_r     <= cfg.height;
      a_pu_r    <= PROD_W'(us) * PROD_W'(mw);
      a_pv_r    <= PROD_W'(vs) * PROD_W'(mh);
    end
  end

  // In nearest mode all four reads point at the one texel, so the corners
  // with zero weight never touch entries that were not written.
  always_comb begin
    ax_u = axis_calc(a_pu_r, a_w_r, a_mode_r);
    ax_v = axis_calc(a_pv_r, a_h_r, a_mode_r);
    tl   = FA_W'(FA_W'(ax_v.corner) * FA_W'(a_w_r)) + FA_W'(ax_u.corner);
    b_entry_nxt.is_write = (a_kind_r == KIND_WRITE);
    b_entry_nxt.waddr    = a_waddr_r;
    b_entry_nxt.wdata    = a_wdata_r;
    b_entry_nxt.a_tl     = tl;
    if (a_mode_r == MODE_NEAREST) begin
      b_entry_nxt.a_tr = tl;
      b_entry_nxt.a_bl = tl;
      b_entry_nxt.a_br = tl;
    end else begin
      b_entry_nxt.a_tr = tl + FA_W'(1);
      b_entry_nxt.a_bl = tl + FA_W'(a_w_r);
      b_entry_nxt.a_br = tl + FA_W'(a_w_r) + FA_W'(1);
    end
    b_entry_nxt.fu       = ax_u.frac;
    b_entry_nxt.omfu     = ax_u.omf;
    b_entry_nxt.fv       = ax_v.frac;
    b_entry_nxt.omfv     = ax_v.omf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
    if (a_valid_r) begin
      b_entry_r <= b_entry_nxt;
    end
  end

  assign q_push  = b_valid_r;
  assign q_entry = b_entry_r;

endmodule
`default_nettype wire

>>> rtl/ts_queue.sv
`default_nettype none
module ts_queue
  import ts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_push,
  input  wire q_entry_t q_in,
  input  wire logic     q_pop,
  output q_entry_t      q_head,
  output q_status_t     q_stat
);

  q_entry_t          slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (q_pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_r + QCNT_W'(q_push) - QCNT_W'(q_pop);
    end
    if (q_push) slot_r[wr_ptr_r] <= q_in;
  end

  assign q_head       = slot_r[rd_ptr_r];
  assign q_stat.count = cnt_r;
  assign q_stat.empty = (cnt_r == '0);

endmodule
`default_nettype wire

>>> rtl/ts_back.sv
`default_nettype none
module ts_back
  import ts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_entry_t  q_head,
  input  wire q_status_t q_stat,
  output logic           q_pop,
  input  wire logic      pop,
  output logic           empty,
  output out_item_t      out_data
);

  // Two copies of the store so the four corner texels are read in the same cycle.
  logic [RGB_W-1:0] mem_top [TEXEL_DEPTH];
  logic [RGB_W-1:0] mem_bot [TEXEL_DEPTH];

  logic                     s1_valid_r;
  logic [RGB_W-1:0]         s1_tex_r [4];
  logic [3:0]               s1_oor_r;
  logic signed [WGT_W-1:0]  s1_wgt_r [4];

  logic                     s2_valid_r;
  logic signed [TERM_W-1:0] s2_term_r [4][3];

  out_item_t                res;
  out_item_t                omem_r [ODEPTH];
  logic [OPTR_W-1:0]        owr_r, ord_r;
  logic [OCNT_W-1:0]        ocnt_r;
  logic [OCNT_W-1:0]        credit;
  logic                     is_samp;

  assign credit  = ocnt_r + OCNT_W'(s1_valid_r) + OCNT_W'(s2_valid_r);
  assign q_pop   = !q_stat.empty && (credit < OCNT_W'(ODEPTH));
  assign is_samp = q_pop && !q_head.is_write;

  always_ff @(posedge clk) begin
    if (q_pop && q_head.is_write) begin
      mem_top[q_head.waddr] <= q_head.wdata;
      mem_bot[q_head.waddr] <= q_head.wdata;
    end
    if (is_samp) begin
      s1_tex_r[0] <= mem_top[q_head.a_tl[ADDR_W-1:0]];
      s1_tex_r[1] <= mem_top[q_head.a_tr[ADDR_W-1:0]];
      s1_tex_r[2] <= mem_bot[q_head.a_bl[ADDR_W-1:0]];
      s1_tex_r[3] <= mem_bot[q_head.a_br[ADDR_W-1:0]];
      s1_oor_r[0] <= (q_head.a_tl >= FA_W'(TEXEL_DEPTH));
      s1_oor_r[1] <= (q_head.a_tr >= FA_W'(TEXEL_DEPTH));
      s1_oor_r[2] <= (q_head.a_bl >= FA_W'(TEXEL_DEPTH));
      s1_oor_r[3] <= (q_head.a_br >= FA_W'(TEXEL_DEPTH));
      s1_wgt_r[0] <= WGT_W'(q_head.omfu) * WGT_W'(q_head.omfv);
      s1_wgt_r[1] <= WGT_W'(q_head.fu) * WGT_W'(q_head.omfv);
      s1_wgt_r[2] <= WGT_W'(q_head.omfu) * WGT_W'(q_head.fv);
      s1_wgt_r[3] <= WGT_W'(q_head.fu) * WGT_W'(q_head.fv);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= is_samp;
      s2_valid_r <= s1_valid_r;
    end
    if (s1_valid_r) begin
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 3; k++) begin
          s2_term_r[c][k] <= TERM_W'(s1_wgt_r[c]) * $signed({1'b0,
            (s1_oor_r[c] ? 8'd0 : s1_tex_r[c][(2-k)*CH_W +: CH_W])});
        end
      end
    end
  end

  // Sum the four weighted corners, round half up and clamp to a byte.
  always_comb begin
    logic signed [SUM_W-1:0] s;
    logic [SUM_W-1:0]        rs;
    logic [CH_W-1:0]         ch [3];
    for (int k = 0; k < 3; k++) begin
      s  = SUM_W'(s2_term_r[0][k]) + SUM_W'(s2_term_r[1][k])
         + SUM_W'(s2_term_r[2][k]) + SUM_W'(s2_term_r[3][k]);
      rs = SUM_W'(s) + SUM_W'(64'h8000_0000);
      if (s[SUM_W-1]) ch[k] = 8'd0;
      else if (rs[SUM_W-1:32] > (SUM_W-32)'(255)) ch[k] = 8'd255;
      else ch[k] = rs[39:32];
    end
    res.red_out   = ch[0];
    res.green_out = ch[1];
    res.blue_out  = ch[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (s2_valid_r) owr_r <= owr_r + OPTR_W'(1);
      if (pop && !empty) ord_r <= ord_r + OPTR_W'(1);
      ocnt_r <= ocnt_r + OCNT_W'(s2_valid_r) - OCNT_W'(pop && !empty);
    end
    if (s2_valid_r) omem_r[owr_r] <= res;
  end

  assign empty    = (ocnt_r == '0);
  assign out_data = omem_r[ord_r];

  a_no_oflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(s2_valid_r && (ocnt_r == OCNT_W'(ODEPTH)) && !pop))
    else $error("result buffer overflow");
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");
  a_wr_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.is_write) |=> !s1_valid_r)
    else $error("texel write produced a result");
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    credit <= OCNT_W'(ODEPTH))
    else $error("result credit exceeded");

endmodule
`default_nettype wire

>>> rtl/texture_sampler_nearest_bilinear.sv
// Texture sampler with nearest and bilinear filtering over a 16384-texel RGB store.
// Input channel: push/full with in_data; a transfer happens when push is high and
// full is low. kind 0 writes texel_rgb at texel_addr, kind 1 samples at coord_u,
// coord_v (unsigned Q1.16). Writes and samples take effect in order.
// Result channel: empty/pop with out_data; one result per sample, none per write,
// taken by a transfer when pop is high and empty is low.
// Configuration: cfg_we with cfg_index and cfg_wdata writes width (0), height (1)
// and filter mode (2); write only while the block is idle, which it does not enforce.
// A sample's result passes the front-end stages, the queue and the back-end stages.
// Throughput: one item per cycle while full is low; the front end computes corners
// and addresses, a short queue decouples it from the back end, whose duplicated
// texel store reads all four corner texels in the same cycle.
// Reset clears the pipeline, the queue and the result buffer and loads width 64,
// height 64 and bilinear mode; the texel store holds nothing defined until written.
// When the receiver stalls, results collect in a four-entry buffer, the back end
// stops drawing from the queue, and full rises once the queue can take no more.
`default_nettype none
module texture_sampler_nearest_bilinear
  import ts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire in_item_t   in_data,
  output logic            full,
  output logic            empty,
  input  wire logic       pop,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  logic [DIM_W-1:0] width_r, height_r;
  logic             mode_r;
  ts_cfg_t          cfg;
  q_status_t        q_stat;
  logic             q_push, q_pop;
  q_entry_t         q_in, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(64);
      height_r <= DIM_W'(64);
      mode_r   <= MODE_BILINEAR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        REG_MODE:   mode_r   <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  // Dimensions outside 2..MAX_DIM act as the nearest bound.
  always_comb begin
    if (width_r < DIM_W'(2)) cfg.width = DIM_W'(2);
    else if (width_r > DIM_W'(MAX_DIM)) cfg.width = DIM_W'(MAX_DIM);
    else cfg.width = width_r;
    if (height_r < DIM_W'(2)) cfg.height = DIM_W'(2);
    else if (height_r > DIM_W'(MAX_DIM)) cfg.height = DIM_W'(MAX_DIM);
    else cfg.height = height_r;
    cfg.mode = mode_r;
  end

  ts_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .full    (full),
    .cfg     (cfg),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  ts_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_in   (q_in),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  ts_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

>>> tb/texture_sampler_nearest_bilinear_tb.sv
`timescale 1ns / 1ps

module texture_sampler_nearest_bilinear_tb;
  import ts_pkg::*;

  // Index that no register answers to; writes there must change nothing.
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int LIMIT_CYCLES = 3000000;
  localparam int DRAIN_CYCLES = 12;

  logic       clk;
  logic       rst_n;
  logic       push;
  in_item_t   in_data;
  logic       full;
  logic       empty;
  logic       pop;
  out_item_t  out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  texture_sampler_nearest_bilinear dut (
    .clk(clk), .rst_n(rst_n), .push(push), .in_data(in_data), .full(full),
    .empty(empty), .pop(pop), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Our own copy of the block's state and registers.
  logic [RGB_W-1:0] texel_mem [TEXEL_DEPTH];
  bit               texel_known [TEXEL_DEPTH];
  logic [7:0]       width_reg;
  logic [7:0]       height_reg;
  logic             mode_reg;

  // Colors that samples are expected to return, oldest first.
  out_item_t expected_colors[$];
  int        mismatch_count;
  int        cycle_count;
  int        items_sent;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // The run never ends on its own if the block hangs; this counter stops it.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int unsigned eff_dim(logic [7:0] r);
    if (r < 2) return 2;
    if (r > MAX_DIM) return MAX_DIM;
    return r;
  endfunction

  function automatic int unsigned clamp_coord(logic [COORD_W-1:0] c);
    return (c > 65536) ? 65536 : c;
  endfunction

  // Top-left corner along one axis and the signed Q.16 fraction past it.
  // The fraction may go negative or above one at the edges, so the blend
  // extrapolates there instead of clamping.
  function automatic void bilinear_axis(int unsigned coord, int unsigned dim,
                                        output int unsigned corner,
                                        output longint frac);
    longint pos;
    pos = longint'(coord) * longint'(dim) - HALF;
    corner = (pos >= 0) ? int'(pos >>> 16) : 0;
    if (corner > dim - 2) corner = dim - 2;
    frac = pos - longint'(corner) * 65536;
  endfunction

  // Store addresses that a sample at (u, v) reads under the current settings.
  function automatic int texel_addrs(logic [COORD_W-1:0] cu, logic [COORD_W-1:0] cv,
                                     output int unsigned addrs[4]);
    int unsigned w, h, u, v, cx, cy;
    longint fu, fv;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    u = clamp_coord(cu);
    v = clamp_coord(cv);
    if (mode_reg == MODE_NEAREST) begin
      cx = (longint'(u) * (w - 1)) >> 16;
      cy = (longint'(v) * (h - 1)) >> 16;
      addrs[0] = cy * w + cx;
      return 1;
    end
    bilinear_axis(u, w, cx, fu);
    bilinear_axis(v, h, cy, fv);
    addrs[0] = cy * w + cx;
    addrs[1] = cy * w + cx + 1;
    addrs[2] = (cy + 1) * w + cx;
    addrs[3] = (cy + 1) * w + cx + 1;
    return 4;
  endfunction

  function automatic logic [RGB_W-1:0] read_texel(int unsigned a);
    return (a >= TEXEL_DEPTH) ? '0 : texel_mem[a];
  endfunction

  function automatic logic [CH_W-1:0] round_saturate(longint s);
    longint r;
    if (s < 0) return 0;
    r = (s + 64'h8000_0000) >>> 32;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic out_item_t sample_color(logic [COORD_W-1:0] cu,
                                             logic [COORD_W-1:0] cv);
    int unsigned addrs[4];
    int n;
    logic [RGB_W-1:0] tl, tr, bl, br;
    longint fu, fv, w_tl, w_bl, w_tr, w_br, acc;
    int unsigned w, h, cx, cy;
    logic [CH_W-1:0] chan[3];
    n = texel_addrs(cu, cv, addrs);
    if (n == 1) return out_item_t'(read_texel(addrs[0]));
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    bilinear_axis(clamp_coord(cu), w, cx, fu);
    bilinear_axis(clamp_coord(cv), h, cy, fv);
    w_tl = (65536 - fu) * (65536 - fv);
    w_bl = (65536 - fu) * fv;
    w_tr = fu * (65536 - fv);
    w_br = fu * fv;
    tl = read_texel(addrs[0]);
    tr = read_texel(addrs[1]);
    bl = read_texel(addrs[2]);
    br = read_texel(addrs[3]);
    for (int k = 0; k < 3; k++) begin
      int sh;
      sh = 16 - 8 * k;
      acc = w_tl * longint'((tl >> sh) & 8'hFF) + w_bl * longint'((bl >> sh) & 8'hFF)
          + w_tr * longint'((tr >> sh) & 8'hFF) + w_br * longint'((br >> sh) & 8'hFF);
      chan[k] = round_saturate(acc);
    end
    return {chan[0], chan[1], chan[2]};
  endfunction

  // Draws a random wait, but half the time none, so there are
  // back-to-back stretches as well as gaps on every pipeline phase.
  function automatic int draw_wait();
    return $urandom_range(0, 1) ? 0 : $urandom_range(0, 10);
  endfunction

  // One input transfer. The expectation is worked out at the accepting edge,
  // so writes and samples update the model in the order the block sees them.
  task automatic send_item(in_item_t item);
    int gap;
    gap = draw_wait();
    repeat (gap) begin
      @(negedge clk);
      push = 1'b0;
    end
    @(negedge clk);
    push = 1'b1;
    in_data = item;
    do @(posedge clk); while (full);
    items_sent++;
    if (item.kind == KIND_WRITE) begin
      texel_mem[item.texel_addr] = item.texel_rgb;
      texel_known[item.texel_addr] = 1'b1;
    end else begin
      expected_colors.push_back(sample_color(item.coord_u, item.coord_v));
    end
  endtask

  task automatic write_texel(int unsigned a, logic [RGB_W-1:0] rgb);
    in_item_t item;
    item = {$urandom, $urandom, $urandom};
    item.kind = KIND_WRITE;
    item.texel_addr = a;
    item.texel_rgb = rgb;
    send_item(item);
  endtask

  // A sample never reads an entry that was never written: any such texel is
  // filled with a random color first.
  task automatic sample_at(logic [COORD_W-1:0] cu, logic [COORD_W-1:0] cv);
    int unsigned addrs[4];
    int n;
    in_item_t item;
    n = texel_addrs(cu, cv, addrs);
    for (int i = 0; i < n; i++)
      if (addrs[i] < TEXEL_DEPTH && !texel_known[addrs[i]])
        write_texel(addrs[i], $urandom);
    item = {$urandom, $urandom, $urandom};
    item.kind = KIND_SAMPLE;
    item.coord_u = cu;
    item.coord_v = cv;
    send_item(item);
  endtask

  // Stops sending and waits until every sample has returned, then keeps waiting
  // so that a trailing write has also left the pipeline.
  task automatic wait_idle();
    @(negedge clk);
    push = 1'b0;
    while (expected_colors.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_WIDTH) width_reg = val;
    else if (idx == REG_HEIGHT) height_reg = val;
    else if (idx == REG_MODE) mode_reg = val[0];
  endtask

  task automatic set_texture(logic [7:0] w, logic [7:0] h, logic mode);
    wait_idle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_MODE, {7'($urandom), mode});
  endtask

  // Coordinates lean on the edges and on values above 1.0, where clamping
  // and extrapolation happen; the rest are spread over the whole field.
  function automatic logic [COORD_W-1:0] draw_coord();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return COORD_ONE;
      2: return $urandom_range(65537, 131071);
      3: return $urandom_range(0, 2048);
      4: return $urandom_range(63488, 65536);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  // Result side: random stalls on pop, then one transfer checked against the
  // oldest expectation.
  initial begin
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      int stall;
      out_item_t want;
      stall = draw_wait();
      repeat (stall) begin
        @(negedge clk);
        pop = 1'b0;
      end
      @(negedge clk);
      pop = 1'b1;
      do @(posedge clk); while (empty);
      if (expected_colors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transfer: %h", out_data);
      end else begin
        want = expected_colors.pop_front();
        if (out_data.red_out !== want.red_out || out_data.green_out !== want.green_out ||
            out_data.blue_out !== want.blue_out) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red_out, want.green_out, want.blue_out,
                     out_data.red_out, out_data.green_out, out_data.blue_out);
        end
      end
    end
  end

  // After reset the block must be 64 by 64 and bilinear.
  task automatic test_reset_defaults();
    sample_at(0, 0);
    sample_at(COORD_ONE, COORD_ONE);
    sample_at(17'h8000, 17'h4123);
  endtask

  // Corner coordinates, saturated coordinates and extreme colors in both modes
  // on the smallest texture, then in nearest mode on the largest.
  task automatic test_edges();
    set_texture(2, 2, MODE_BILINEAR);
    write_texel(0, 24'hFFFFFF);
    write_texel(1, 24'h000000);
    write_texel(2, 24'hFF00FF);
    write_texel(3, 24'h00FF00);
    sample_at(0, 0);
    sample_at(COORD_ONE, COORD_ONE);
    sample_at(17'h1FFFF, 0);
    sample_at(0, 17'h1FFFF);
    sample_at(17'h8000, 17'h8000);
    set_texture(2, 2, MODE_NEAREST);
    sample_at(0, 0);
    sample_at(COORD_ONE, 0);
    sample_at(17'h1FFFF, 17'h1FFFF);
    sample_at(17'hFFFF, 17'hFFFF);
    set_texture(128, 128, MODE_NEAREST);
    write_texel(16383, 24'hABCDEF);
    sample_at(COORD_ONE, COORD_ONE);
    sample_at(0, COORD_ONE);
  endtask

  // Width and height registers outside 2..128 act as the nearest bound; an
  // unused register index changes nothing.
  task automatic test_dim_clamp();
    set_texture(0, 255, MODE_BILINEAR);
    write_reg(REG_NONE, 8'hFF);
    sample_at(COORD_ONE, COORD_ONE);
    sample_at(17'h5555, 17'hAAAA);
    set_texture(1, 200, MODE_NEAREST);
    sample_at(COORD_ONE, COORD_ONE);
    sample_at(17'h1234, 17'hFEDC);
  endtask

  // Random phases over several texture settings until the run has sent about
  // the given total of items, fill writes included. Most items are samples of
  // a filled area; writes repaint texels in and beyond the area in use.
  task automatic test_random_mix(int items);
    int unsigned w, h;
    while (items_sent < items) begin
      int phase_len;
      case ($urandom_range(0, 5))
        0: set_texture(2, 2, $urandom_range(0, 1));
        1: set_texture(128, 128, $urandom_range(0, 1));
        2: set_texture($urandom_range(0, 1), $urandom_range(129, 255), $urandom_range(0, 1));
        default: set_texture($urandom_range(2, 16), $urandom_range(2, 16),
                             $urandom_range(0, 1));
      endcase
      w = eff_dim(width_reg);
      h = eff_dim(height_reg);
      phase_len = $urandom_range(60, 160);
      for (int i = 0; i < phase_len && items_sent < items; i++) begin
        case ($urandom_range(0, 9))
          0: write_texel($urandom_range(0, TEXEL_DEPTH - 1), $urandom);
          1, 2, 3: write_texel($urandom_range(0, w * h - 1), $urandom);
          default: sample_at(draw_coord(), draw_coord());
        endcase
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_wdata = '0;
    mismatch_count = 0;
    cycle_count = 0;
    items_sent = 0;
    width_reg = 8'd64;
    height_reg = 8'd64;
    mode_reg = MODE_BILINEAR;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_edges();
    test_dim_clamp();
    test_random_mix(1300);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
